### rtl/core/assert_macros.svh
// Assertion macros used by the checker file of this project.
// Needs clk and rst_n in scope at the place of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that an antecedent implies a consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/i2cbb_pkg.sv
// Package for the I2C bit-level master: command codes and request/result payloads.
// No dependencies; used by the core and its checker.
`default_nettype none

package i2cbb_pkg;

  typedef enum logic [2:0] {
    CMD_IDLE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_READ  = 3'd4,
    CMD_ACK   = 3'd5,
    CMD_NACK  = 3'd6
  } cmd_t;

  localparam logic [7:0] TICKS_RESET = 8'd1;
  localparam logic [3:0] LAST_BIT    = 4'd7;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] write_byte;
    logic       sda_in;
  } in_t;

  typedef struct packed {
    logic       scl;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       ack_seen;
  } out_t;

endpackage

`default_nettype wire

### rtl/core/i2c_bitbang_master_core.sv
// I2C bit-level master sequencer, top level.
// Depends on i2cbb_pkg for command codes and the request/result structs.
//
// Each request is one tick of the bus sequencer: it carries the command code
// (taken only while idle), the byte to write and the sampled SDA level, and
// yields exactly one result with the driven SCL/SDA levels, busy/done flags,
// the last byte read and the last acknowledge sampled. A request is taken
// every cycle while not stalled: state updates in one pass of logic between
// the sequencer registers and a single result register, so throughput
// is one request per clock unless stalled. in_stall rises only when the
// result register is full and the consumer stalls it. Each pin phase lasts
// ticks_per_delay requests (zero acts as one); write cfg_data only while idle.
`default_nettype none

module i2c_bitbang_master_core (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  input  i2cbb_pkg::in_t     in_data,
  output logic               out_valid,
  input  wire                out_stall,
  output i2cbb_pkg::out_t    out_data,
  input  wire                cfg_valid,
  output logic               cfg_ready,
  input  wire [7:0]          cfg_data
);

  // sequencer state
  i2cbb_pkg::cmd_t cmd_r, cmd_nxt;
  logic [4:0]      phase_r, phase_nxt;
  logic [3:0]      bit_r, bit_nxt;
  logic [7:0]      delay_r, delay_nxt;
  logic [7:0]      shift_r, shift_nxt;
  logic            scl_r, scl_nxt;
  logic            sda_r, sda_nxt;
  logic            ack_r, ack_nxt;
  logic [7:0]      rdata_r, rdata_nxt;
  logic            done_nxt;

  // configuration
  logic [7:0]      tpd_r;

  // result register
  logic            out_valid_r, out_valid_nxt;
  i2cbb_pkg::out_t out_data_r, out_data_nxt;

  logic            in_take;
  logic [7:0]      hold_ticks;

  // Stall the producer only while a result is waiting and the consumer holds it.
  assign in_stall   = out_valid_r & out_stall;
  assign in_take    = in_valid & ~in_stall;
  assign cfg_ready  = 1'b1;
  assign hold_ticks = (tpd_r == 8'd0) ? 8'd1 : tpd_r;

  // Next state: one tick of the sequencer.
  always_comb begin
    logic enter;
    cmd_nxt   = cmd_r;
    phase_nxt = phase_r;
    bit_nxt   = bit_r;
    delay_nxt = delay_r;
    shift_nxt = shift_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    ack_nxt   = ack_r;
    rdata_nxt = rdata_r;
    done_nxt  = 1'b0;
    enter     = 1'b0;

    if (in_take) begin
      if (cmd_r == i2cbb_pkg::CMD_IDLE) begin
        // Take a new command; codes none and seven are dropped.
        if (in_data.action >= 3'(i2cbb_pkg::CMD_START) &&
            in_data.action <= 3'(i2cbb_pkg::CMD_NACK)) begin
          cmd_nxt   = i2cbb_pkg::cmd_t'(in_data.action);
          phase_nxt = 5'd0;
          bit_nxt   = 4'd0;
          if (cmd_nxt == i2cbb_pkg::CMD_WRITE) begin
            shift_nxt = in_data.write_byte;
          end else if (cmd_nxt == i2cbb_pkg::CMD_READ) begin
            shift_nxt = 8'd0;
          end
          enter = 1'b1;
        end
      end else if (delay_r > 8'd1) begin
        delay_nxt = delay_r - 8'd1;
      end else begin
        // Interval over: advance to the next phase.
        if (cmd_r == i2cbb_pkg::CMD_WRITE && phase_r == 5'd1) begin
          scl_nxt   = 1'b0;
          shift_nxt = {shift_r[6:0], 1'b0};
          if (bit_r < i2cbb_pkg::LAST_BIT) begin
            bit_nxt   = bit_r + 4'd1;
            phase_nxt = 5'd0;
          end else begin
            phase_nxt = 5'd2;
          end
        end else if (cmd_r == i2cbb_pkg::CMD_READ && phase_r == 5'd1) begin
          scl_nxt   = 1'b0;
          shift_nxt = {shift_r[6:0], in_data.sda_in};
          if (bit_r < i2cbb_pkg::LAST_BIT) begin
            bit_nxt   = bit_r + 4'd1;
            phase_nxt = 5'd0;
          end else begin
            rdata_nxt = shift_nxt;
            phase_nxt = 5'd2;
          end
        end else begin
          phase_nxt = phase_r + 5'd1;
        end
        enter = 1'b1;
      end
    end

    // Apply the pin levels of the phase just entered.
    if (enter) begin
      case (cmd_nxt)
        i2cbb_pkg::CMD_START: begin
          if (phase_nxt == 5'd0) begin
            scl_nxt = 1'b1; sda_nxt = 1'b1; delay_nxt = hold_ticks;
          end else if (phase_nxt == 5'd1) begin
            sda_nxt = 1'b0; delay_nxt = hold_ticks;
          end else begin
            scl_nxt = 1'b0; done_nxt = 1'b1;
          end
        end
        i2cbb_pkg::CMD_STOP: begin
          if (phase_nxt == 5'd0) begin
            scl_nxt = 1'b0; sda_nxt = 1'b0; delay_nxt = hold_ticks;
          end else if (phase_nxt == 5'd1) begin
            scl_nxt = 1'b1; delay_nxt = hold_ticks;
          end else begin
            sda_nxt = 1'b1; done_nxt = 1'b1;
          end
        end
        i2cbb_pkg::CMD_WRITE: begin
          if (phase_nxt == 5'd0) begin
            sda_nxt = shift_nxt[7]; delay_nxt = hold_ticks;
          end else if (phase_nxt == 5'd1) begin
            scl_nxt = 1'b1; delay_nxt = hold_ticks;
          end else if (phase_nxt == 5'd2) begin
            scl_nxt = 1'b0; sda_nxt = 1'b1; delay_nxt = hold_ticks;
          end else if (phase_nxt == 5'd3) begin
            scl_nxt = 1'b1; delay_nxt = hold_ticks;
          end else if (phase_nxt == 5'd4) begin
            ack_nxt = in_data.sda_in; scl_nxt = 1'b0; delay_nxt = hold_ticks;
          end else begin
            done_nxt = 1'b1;
          end
        end
        i2cbb_pkg::CMD_READ: begin
          if (phase_nxt == 5'd0) begin
            delay_nxt = hold_ticks;
          end else if (phase_nxt == 5'd1) begin
            scl_nxt = 1'b1; delay_nxt = hold_ticks;
          end else begin
            done_nxt = 1'b1;
          end
        end
        i2cbb_pkg::CMD_ACK: begin
          if (phase_nxt == 5'd0) begin
            sda_nxt = 1'b0; delay_nxt = hold_ticks;
          end else if (phase_nxt == 5'd1) begin
            delay_nxt = hold_ticks;
          end else if (phase_nxt == 5'd2) begin
            scl_nxt = 1'b1; delay_nxt = hold_ticks;
          end else begin
            scl_nxt = 1'b0; sda_nxt = 1'b1; done_nxt = 1'b1;
          end
        end
        default: begin
          // nack: SCL ends high
          if (phase_nxt == 5'd0) begin
            sda_nxt = 1'b1; delay_nxt = hold_ticks;
          end else if (phase_nxt == 5'd1) begin
            delay_nxt = hold_ticks;
          end else if (phase_nxt == 5'd2) begin
            scl_nxt = 1'b1; delay_nxt = hold_ticks;
          end else begin
            scl_nxt = 1'b1; done_nxt = 1'b1;
          end
        end
      endcase
      // Finishing phase drops back to idle with counters cleared.
      if (done_nxt) begin
        cmd_nxt   = i2cbb_pkg::CMD_IDLE;
        phase_nxt = 5'd0;
        bit_nxt   = 4'd0;
        delay_nxt = 8'd0;
      end
    end
  end

  // Outputs: build the result for this tick and manage the result register.
  always_comb begin
    out_data_nxt.scl       = scl_nxt;
    out_data_nxt.sda_out   = sda_nxt;
    out_data_nxt.busy_res  = (cmd_nxt != i2cbb_pkg::CMD_IDLE);
    out_data_nxt.done_res  = done_nxt;
    out_data_nxt.read_byte = rdata_nxt;
    out_data_nxt.ack_seen  = ack_nxt;
    if (in_take) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r       <= i2cbb_pkg::CMD_IDLE;
      phase_r     <= 5'd0;
      bit_r       <= 4'd0;
      delay_r     <= 8'd0;
      shift_r     <= 8'd0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      ack_r       <= 1'b1;
      rdata_r     <= 8'd0;
      tpd_r       <= i2cbb_pkg::TICKS_RESET;
      out_valid_r <= 1'b0;
    end else begin
      cmd_r       <= cmd_nxt;
      phase_r     <= phase_nxt;
      bit_r       <= bit_nxt;
      delay_r     <= delay_nxt;
      shift_r     <= shift_nxt;
      scl_r       <= scl_nxt;
      sda_r       <= sda_nxt;
      ack_r       <= ack_nxt;
      rdata_r     <= rdata_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        tpd_r <= cfg_data;
      end
    end
  end

  // Load the result only when a request is taken; hold it otherwise.
  always_ff @(posedge clk) begin
    if (in_take) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

### rtl/core/i2cbb_checker.sv
// Port-level checker for the I2C bit-level master core, with its bind.
// Depends on i2cbb_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module i2cbb_checker (
  input wire             clk,
  input wire             rst_n,
  input wire             in_valid,
  input wire             in_stall,
  input i2cbb_pkg::in_t  in_data,
  input wire             out_valid,
  input wire             out_stall,
  input i2cbb_pkg::out_t out_data
);

  // A held result keeps its payload.
  `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "result changed while stalled")
  // Every taken request yields a result next cycle.
  `ASSERT_NEXT(a_req_result, in_valid && !in_stall, out_valid, "request without result")
  // A finishing tick never reports busy.
  `ASSERT_CLK(a_done_idle, !(out_valid && out_data.done_res && out_data.busy_res), "done while busy")
  // Empty result register never stalls the producer.
  `ASSERT_CLK(a_no_stall_empty, out_valid || !in_stall, "stall with empty result register")

endmodule

bind i2c_bitbang_master_core i2cbb_checker u_i2cbb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

### dv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the I2C bit-level master core (i2c_bitbang_master_core).
// Needs i2cbb_pkg; predicts every per-tick result in-house and compares it field by field.

module tb;

  // Action code with no command behind it; the block must treat it like none.
  localparam logic [2:0] ACT_RESERVED = 3'd7;
  // Give up after this many cycles with no request, result or register write moving.
  localparam int QUIET_LIMIT = 5000;
  // Length of the deliberate receiver hold-off that fills the block up.
  localparam int HOLD_CYCLES = 300;

  logic            clk;
  logic            rst_n;
  logic            in_valid;
  logic            in_stall;
  i2cbb_pkg::in_t  in_data;
  logic            out_valid;
  logic            out_stall;
  i2cbb_pkg::out_t out_data;
  logic            cfg_valid;
  logic            cfg_ready;
  logic [7:0]      cfg_data;

  i2c_bitbang_master_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Bus sequencer mirror: configuration, command state and pin levels.
  logic [7:0]      m_ticks;
  i2cbb_pkg::cmd_t m_cmd;
  logic [4:0]      m_phase;
  logic [3:0]      m_bit;
  logic [7:0]      m_delay;
  logic [7:0]      m_shift;
  logic            m_scl;
  logic            m_sda;
  logic            m_ack;
  logic [7:0]      m_read;
  logic            m_done;

  // Pin levels and flags still owed by the block, oldest first.
  i2cbb_pkg::out_t pin_levels_q[$];

  int  errors;
  int  ticks_sent;
  int  cmds_issued;
  int  results_seen;
  int  quiet_cycles;
  bit  gaps_on;
  bit  stalls_on;
  bit  hold_pending;
  int  hold_left;
  int  stall_left;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Load one delay interval; a zero register still gives one tick.
  function automatic void start_interval();
    m_delay = (m_ticks == 8'd0) ? 8'd1 : m_ticks;
  endfunction

  function automatic void end_command();
    m_cmd   = i2cbb_pkg::CMD_IDLE;
    m_phase = '0;
    m_bit   = '0;
    m_delay = '0;
    m_done  = 1'b1;
  endfunction

  // Set the pins of the current phase, then hold them or close the command.
  function automatic void enter_phase(logic sda);
    case (m_cmd)
      i2cbb_pkg::CMD_START: begin
        if (m_phase == 0) begin
          m_scl = 1'b1; m_sda = 1'b1; start_interval();
        end else if (m_phase == 1) begin
          m_sda = 1'b0; start_interval();
        end else begin
          m_scl = 1'b0; end_command();
        end
      end
      i2cbb_pkg::CMD_STOP: begin
        if (m_phase == 0) begin
          m_scl = 1'b0; m_sda = 1'b0; start_interval();
        end else if (m_phase == 1) begin
          m_scl = 1'b1; start_interval();
        end else begin
          m_sda = 1'b1; end_command();
        end
      end
      i2cbb_pkg::CMD_WRITE: begin
        if (m_phase == 0) begin
          m_sda = m_shift[7]; start_interval();
        end else if (m_phase == 1) begin
          m_scl = 1'b1; start_interval();
        end else if (m_phase == 2) begin
          m_scl = 1'b0; m_sda = 1'b1; start_interval();
        end else if (m_phase == 3) begin
          m_scl = 1'b1; start_interval();
        end else if (m_phase == 4) begin
          m_ack = sda; m_scl = 1'b0; start_interval();
        end else begin
          end_command();
        end
      end
      i2cbb_pkg::CMD_READ: begin
        if (m_phase == 0) begin
          start_interval();
        end else if (m_phase == 1) begin
          m_scl = 1'b1; start_interval();
        end else begin
          end_command();
        end
      end
      i2cbb_pkg::CMD_ACK: begin
        if (m_phase == 0) begin
          m_sda = 1'b0; start_interval();
        end else if (m_phase == 1) begin
          start_interval();
        end else if (m_phase == 2) begin
          m_scl = 1'b1; start_interval();
        end else begin
          m_scl = 1'b0; m_sda = 1'b1; end_command();
        end
      end
      default: begin
        // Nack: the closing low pulse on SCL nets out, so SCL stays high.
        if (m_phase == 0) begin
          m_sda = 1'b1; start_interval();
        end else if (m_phase == 1) begin
          start_interval();
        end else if (m_phase == 2) begin
          m_scl = 1'b1; start_interval();
        end else begin
          m_scl = 1'b1; end_command();
        end
      end
    endcase
  endfunction

  // Work out the result of one tick and advance the mirror.
  function automatic i2cbb_pkg::out_t sequencer_tick(i2cbb_pkg::in_t req);
    i2cbb_pkg::out_t res;
    m_done = 1'b0;
    if (m_cmd == i2cbb_pkg::CMD_IDLE) begin
      if (req.action >= i2cbb_pkg::CMD_START && req.action <= i2cbb_pkg::CMD_NACK) begin
        m_cmd   = i2cbb_pkg::cmd_t'(req.action);
        m_phase = '0;
        m_bit   = '0;
        if (m_cmd == i2cbb_pkg::CMD_WRITE) m_shift = req.write_byte;
        else if (m_cmd == i2cbb_pkg::CMD_READ) m_shift = '0;
        enter_phase(req.sda_in);
      end
    end else if (m_delay > 8'd1) begin
      m_delay = m_delay - 8'd1;
    end else begin
      if (m_cmd == i2cbb_pkg::CMD_WRITE && m_phase == 1) begin
        m_scl   = 1'b0;
        m_shift = {m_shift[6:0], 1'b0};
        if (m_bit < i2cbb_pkg::LAST_BIT) begin
          m_bit = m_bit + 4'd1; m_phase = '0;
        end else begin
          m_phase = 5'd2;
        end
      end else if (m_cmd == i2cbb_pkg::CMD_READ && m_phase == 1) begin
        m_scl   = 1'b0;
        m_shift = {m_shift[6:0], req.sda_in};
        if (m_bit < i2cbb_pkg::LAST_BIT) begin
          m_bit = m_bit + 4'd1; m_phase = '0;
        end else begin
          m_read = m_shift; m_phase = 5'd2;
        end
      end else begin
        m_phase = m_phase + 5'd1;
      end
      enter_phase(req.sda_in);
    end
    res.scl       = m_scl;
    res.sda_out   = m_sda;
    res.busy_res  = (m_cmd != i2cbb_pkg::CMD_IDLE);
    res.done_res  = m_done;
    res.read_byte = m_read;
    res.ack_seen  = m_ack;
    return res;
  endfunction

  function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s mismatch: expected %0h, actual %0h", name, exp_v, got_v);
      errors++;
    end
  endfunction

  // Offer one request at a falling edge, hold it until taken, then predict it.
  task automatic send_tick(input logic [2:0] act, input logic [7:0] wb, input logic sda);
    i2cbb_pkg::in_t req;
    int             g;
    req.action     = act;
    req.write_byte = wb;
    req.sda_in     = sda;
    g = gaps_on ? gap_len() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pin_levels_q.push_back(sequencer_tick(req));
    ticks_sent++;
    @(negedge clk);
  endtask

  // Issue one command and tick the sequencer until it is idle again.
  // rd_bits feeds SDA during a read, MSB first; ack_bit is SDA otherwise.
  // With noisy set, the busy ticks carry random actions that must be ignored.
  task automatic run_command(input logic [2:0] op, input logic [7:0] wb,
                             input logic [7:0] rd_bits, input logic ack_bit, input bit noisy);
    logic [2:0] act;
    logic       sda;
    send_tick(op, wb, ack_bit);
    cmds_issued++;
    while (m_cmd != i2cbb_pkg::CMD_IDLE) begin
      act = noisy ? 3'($urandom_range(0, 7)) : i2cbb_pkg::CMD_IDLE;
      sda = (m_cmd == i2cbb_pkg::CMD_READ) ? rd_bits[7 - m_bit] : ack_bit;
      send_tick(act, 8'($urandom), sda);
    end
  endtask

  // Drop the request line, drain every owed result, then write the register.
  task automatic set_tick_count(input logic [7:0] value);
    in_valid <= 1'b0;
    while (pin_levels_q.size() != 0) @(posedge clk);
    // Let the block settle before touching the register.
    repeat (4) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    m_ticks = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_directed_commands();
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    // Write straight out of reset: SCL stays high through the first bit.
    run_command(i2cbb_pkg::CMD_WRITE, 8'hFF, 8'h00, 1'b0, 1'b0);
    run_command(i2cbb_pkg::CMD_START, 8'h00, 8'h00, 1'b1, 1'b0);
    // Write after start: SCL low while the first bit is set up; slave nacks.
    run_command(i2cbb_pkg::CMD_WRITE, 8'h00, 8'h00, 1'b1, 1'b0);
    run_command(i2cbb_pkg::CMD_WRITE, 8'hA5, 8'h00, 1'b0, 1'b1);
    run_command(i2cbb_pkg::CMD_READ, 8'h00, 8'hFF, 1'b1, 1'b0);
    run_command(i2cbb_pkg::CMD_READ, 8'h00, 8'h00, 1'b0, 1'b0);
    run_command(i2cbb_pkg::CMD_READ, 8'h00, 8'h5A, 1'b1, 1'b1);
    run_command(i2cbb_pkg::CMD_ACK, 8'h00, 8'h00, 1'b0, 1'b0);
    run_command(i2cbb_pkg::CMD_NACK, 8'h00, 8'h00, 1'b1, 1'b0);
    run_command(i2cbb_pkg::CMD_STOP, 8'h00, 8'h00, 1'b1, 1'b1);
    run_command(ACT_RESERVED, 8'h3C, 8'h00, 1'b0, 1'b0);
    run_command(i2cbb_pkg::CMD_IDLE, 8'hC3, 8'h00, 1'b1, 1'b0);
  endtask

  // Register at zero must behave like one tick per interval.
  task automatic test_zero_delay();
    set_tick_count(8'd0);
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    run_command(i2cbb_pkg::CMD_START, 8'h00, 8'h00, 1'b1, 1'b0);
    run_command(i2cbb_pkg::CMD_WRITE, 8'($urandom), 8'h00, 1'($urandom), 1'b1);
    run_command(i2cbb_pkg::CMD_READ, 8'h00, 8'($urandom), 1'b0, 1'b1);
    run_command(i2cbb_pkg::CMD_NACK, 8'h00, 8'h00, 1'b1, 1'b0);
    run_command(i2cbb_pkg::CMD_STOP, 8'h00, 8'h00, 1'b1, 1'b0);
  endtask

  // Mostly well-formed transfers with random bytes; some stray commands and idle ticks.
  task automatic test_random_traffic(input int n_ticks);
    int   stop_at;
    int   r;
    logic [2:0] op;
    stop_at = ticks_sent + n_ticks;
    while (ticks_sent < stop_at) begin
      if ($urandom_range(0, 9) == 0) gaps_on = ~gaps_on;
      if ($urandom_range(0, 9) == 0) stalls_on = ~stalls_on;
      r = $urandom_range(0, 99);
      if (r < 70) begin
        // One transaction: start, address, a few data bytes, ack or nack, stop.
        run_command(i2cbb_pkg::CMD_START, 8'h00, 8'h00, 1'($urandom), 1'($urandom));
        run_command(i2cbb_pkg::CMD_WRITE, 8'($urandom), 8'h00, 1'($urandom),
                    1'($urandom));
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(0, 1)) begin
            run_command(i2cbb_pkg::CMD_READ, 8'h00, 8'($urandom), 1'($urandom),
                        1'($urandom));
            run_command($urandom_range(0, 1) ? i2cbb_pkg::CMD_ACK : i2cbb_pkg::CMD_NACK,
                        8'h00, 8'h00, 1'($urandom), 1'($urandom));
          end else begin
            run_command(i2cbb_pkg::CMD_WRITE, 8'($urandom), 8'h00, 1'($urandom),
                        1'($urandom));
          end
        end
        run_command(i2cbb_pkg::CMD_STOP, 8'h00, 8'h00, 1'($urandom), 1'($urandom));
      end else begin
        op = 3'($urandom_range(0, 7));
        run_command(op, 8'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
      end
    end
  endtask

  // Hold the receiver off for a long stretch while requests keep coming.
  task automatic test_backpressure();
    set_tick_count(8'd1);
    gaps_on      = 1'b0;
    stalls_on    = 1'b0;
    hold_pending = 1'b1;
    run_command(i2cbb_pkg::CMD_START, 8'h00, 8'h00, 1'b1, 1'b0);
    repeat (6) run_command(i2cbb_pkg::CMD_WRITE, 8'($urandom), 8'h00, 1'($urandom), 1'b1);
    run_command(i2cbb_pkg::CMD_STOP, 8'h00, 8'h00, 1'b1, 1'b0);
  endtask

  // Widest interval: one start alone already takes about five hundred ticks.
  task automatic test_slowest_delay();
    set_tick_count(8'd255);
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    run_command(i2cbb_pkg::CMD_START, 8'h00, 8'h00, 1'b1, 1'b1);
  endtask

  // Receiver: random stalls, plus the long hold-off when one is requested.
  initial begin
    out_stall  = 1'b0;
    hold_left  = 0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!stalls_on) begin
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall  <= 1'b0;
        stall_left = gap_len();
      end
    end
  end

  // Compare each accepted result with the oldest owed one.
  always @(posedge clk) begin
    i2cbb_pkg::out_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pin_levels_q.size() == 0) begin
        $error("result accepted with nothing expected");
        errors++;
      end else begin
        exp_r = pin_levels_q.pop_front();
        check_field("scl", 8'(exp_r.scl), 8'(out_data.scl));
        check_field("sda_out", 8'(exp_r.sda_out), 8'(out_data.sda_out));
        check_field("busy_res", 8'(exp_r.busy_res), 8'(out_data.busy_res));
        check_field("done_res", 8'(exp_r.done_res), 8'(out_data.done_res));
        check_field("read_byte", exp_r.read_byte, out_data.read_byte);
        check_field("ack_seen", 8'(exp_r.ack_seen), 8'(out_data.ack_seen));
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no handshake for %0d cycles", QUIET_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    errors       = 0;
    ticks_sent   = 0;
    cmds_issued  = 0;
    results_seen = 0;
    gaps_on      = 1'b0;
    stalls_on    = 1'b0;
    hold_pending = 1'b0;
    // Reset state of the mirror.
    m_ticks = i2cbb_pkg::TICKS_RESET;
    m_cmd   = i2cbb_pkg::CMD_IDLE;
    m_phase = '0;
    m_bit   = '0;
    m_delay = '0;
    m_shift = '0;
    m_scl   = 1'b1;
    m_sda   = 1'b1;
    m_ack   = 1'b1;
    m_read  = '0;
    m_done  = 1'b0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed_commands();
    test_zero_delay();
    set_tick_count(8'd2);
    test_random_traffic(330);
    test_backpressure();
    test_random_traffic(330);
    set_tick_count(8'd3);
    test_random_traffic(230);
    test_slowest_delay();

    // Drain what is owed, then let the pipeline settle.
    in_valid <= 1'b0;
    while (pin_levels_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Covered %0d ticks and %0d commands, delays 0, 1, 2, 3 and 255;",
             ticks_sent, cmds_issued);
    $display("checked %0d results under random gaps, stalls and one long hold-off.",
             results_seen);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/i2cbb_pkg.sv
rtl/core/i2c_bitbang_master_core.sv
rtl/core/i2cbb_checker.sv
dv/tb.sv
